@@ rtl/bitmap_page_allocator_assert.svh @@
// assertion macros for the bitmap page allocator checker
// expects clk and rst_n in the scope of the module that uses them
`ifndef BITMAP_PAGE_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BPA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bpa_pkg.sv @@
// shared types and constants of the bitmap page allocator
// used by the controller, the datapath, the top level and the checker
package bpa_pkg;

    localparam int FRAME_W            = 52;
    localparam int PAGE_CNT_W         = 13;
    localparam int CFG_IDX_W          = 1;
    localparam int CFG_DATA_W         = 52;
    localparam int S_TDATA_W          = 56;
    localparam int M_TDATA_W          = 72;
    localparam int M_PAD_W            = M_TDATA_W - FRAME_W - PAGE_CNT_W;
    localparam int DEF_MAX_PAGES      = 4096;
    localparam int DEF_REGION_PAGES   = 4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_PAGE,
        REG_REGION_PAGES
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_NO_FREE,
        ST_OUT_OF_RANGE,
        ST_DOUBLE_FREE
    } alloc_status_t;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // map word width, keeps the row count at or below 256
    function automatic int word_bits(input int max_pages);
        return (max_pages > 16384) ? 256 : 64;
    endfunction

    typedef struct packed {
        logic          load;
        logic          sub;
        logic          rd_first;
        logic          rd_next;
        logic          rd_free;
        logic          capture;
        logic          alloc_wr;
        logic          free_wr;
        logic          respond;
        alloc_status_t code;
    } bpa_cmd_t;

    typedef struct packed {
        logic mode_free;
        logic no_free;
        logic hit;
        logic in_range;
        logic bit_set;
        logic out_free;
    } bpa_stat_t;

endpackage

@@ rtl/bpa_ctrl.sv @@
// controller state machine of the bitmap page allocator
// depends on bpa_pkg; drives the datapath through bpa_cmd_t
module bpa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  bpa_pkg::bpa_stat_t  stat,
    output bpa_pkg::bpa_cmd_t   cmd
);
    import bpa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_ALLOC_WR,
        S_FREE_CHK,
        S_FREE_EVAL,
        S_RESP
    } ctrl_state_t;

    ctrl_state_t   state_reg, state_next;
    alloc_status_t code_reg, code_next;
    logic          ready_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        code_next  = code_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && ready_reg)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.mode_free)
                begin
                    cmd.sub    = 1'b1;
                    state_next = S_FREE_CHK;
                end
                else if (stat.no_free)
                begin
                    code_next  = ST_NO_FREE;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.rd_first = 1'b1;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.hit)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_ALLOC_WR;
                end
                else
                begin
                    cmd.rd_next = 1'b1;
                end
            end
            S_ALLOC_WR:
            begin
                cmd.alloc_wr = 1'b1;
                code_next    = ST_OK;
                state_next   = S_RESP;
            end
            S_FREE_CHK:
            begin
                if (!stat.in_range)
                begin
                    code_next  = ST_OUT_OF_RANGE;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.rd_free = 1'b1;
                    state_next  = S_FREE_EVAL;
                end
            end
            S_FREE_EVAL:
            begin
                if (!stat.bit_set)
                begin
                    code_next = ST_DOUBLE_FREE;
                end
                else
                begin
                    cmd.free_wr = 1'b1;
                    code_next   = ST_OK;
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.respond = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        cmd.code = code_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= ST_OK;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
            ready_reg <= (state_next == S_IDLE);
        end
    end

    assign s_tready = ready_reg;

endmodule

@@ rtl/bpa_datapath.sv @@
// datapath of the bitmap page allocator: region registers, map memory,
// word scan, hint, free count and output register; depends on bpa_pkg
module bpa_datapath #(
    parameter int MAX_PAGES = bpa_pkg::DEF_MAX_PAGES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bpa_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [bpa_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bpa_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [1:0]                        m_tuser,
    input  bpa_pkg::bpa_cmd_t                 cmd,
    output bpa_pkg::bpa_stat_t                stat
);
    import bpa_pkg::*;

    localparam int WORD_BITS = word_bits(MAX_PAGES);
    localparam int ROWS      = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int IDX_W     = ROW_W + BIT_W;

    function automatic logic [PAGE_CNT_W-1:0] clamp_pages(input logic [PAGE_CNT_W-1:0] n);
        return (32'(n) > MAX_PAGES) ? PAGE_CNT_W'(MAX_PAGES) : n;
    endfunction

    logic [FRAME_W-1:0]    base_reg;
    logic [PAGE_CNT_W-1:0] pages_reg;
    logic [ROWS-1:0]       valid_reg;
    logic [WORD_BITS-1:0]  map_mem [ROWS];
    logic [WORD_BITS-1:0]  rdata_reg;
    logic                  rvalid_reg;
    logic [ROW_W-1:0]      row_reg;
    logic                  first_reg;
    logic [IDX_W-1:0]      hint_reg;
    logic [PAGE_CNT_W-1:0] free_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic                  mode_reg;
    logic [FRAME_W-1:0]    pn_reg;
    logic [FRAME_W:0]      diff_reg;
    logic [FRAME_W-1:0]    frame_reg;
    logic                  out_valid_reg;
    alloc_status_t         out_status_reg;
    logic [FRAME_W-1:0]    out_frame_reg;
    logic [PAGE_CNT_W-1:0] out_count_reg;

    logic [PAGE_CNT_W-1:0] eff_pages;
    logic [PAGE_CNT_W-1:0] pages_next;
    logic [IDX_W-1:0]      last_idx;
    logic [ROW_W-1:0]      last_row;
    logic [BIT_W-1:0]      last_bit;
    logic [ROW_W-1:0]      start_row;
    logic [BIT_W-1:0]      start_bit;
    logic [ROW_W-1:0]      next_row;
    logic [IDX_W-1:0]      free_idx;
    logic [ROW_W-1:0]      free_row;
    logic [BIT_W-1:0]      free_bit;
    logic [WORD_BITS-1:0]  word;
    logic [WORD_BITS-1:0]  cand;
    logic                  hit;
    logic [BIT_W-1:0]      hit_bit;
    logic                  rd_en;
    logic [ROW_W-1:0]      rd_addr;
    logic                  wr_en;
    logic [WORD_BITS-1:0]  wr_word;
    logic [IDX_W-1:0]      hint_next;

    assign eff_pages = clamp_pages(pages_reg);
    assign last_idx  = IDX_W'(eff_pages - PAGE_CNT_W'(1));
    assign last_row  = last_idx[IDX_W-1:BIT_W];
    assign last_bit  = last_idx[BIT_W-1:0];
    assign start_row = hint_reg[IDX_W-1:BIT_W];
    assign start_bit = hint_reg[BIT_W-1:0];
    assign next_row  = (row_reg == last_row) ? '0 : row_reg + ROW_W'(1);
    assign free_idx  = diff_reg[IDX_W-1:0];
    assign free_row  = free_idx[IDX_W-1:BIT_W];
    assign free_bit  = free_idx[BIT_W-1:0];
    assign word      = rvalid_reg ? rdata_reg : '0;

    // candidate bits: clear, inside the region, at or past the hint on the first row
    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            cand[b] = !word[b]
                   && ((row_reg != last_row) || (BIT_W'(b) <= last_bit))
                   && (!first_reg || (BIT_W'(b) >= start_bit));
        end
    end

    // lowest candidate wins
    always_comb
    begin
        hit_bit = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (cand[b])
            begin
                hit_bit = BIT_W'(b);
            end
        end
    end

    assign hit = |cand;

    assign rd_en   = cmd.rd_first || cmd.rd_next || cmd.rd_free;
    assign rd_addr = cmd.rd_first ? start_row : (cmd.rd_next ? next_row : free_row);
    assign wr_en   = cmd.alloc_wr || cmd.free_wr;
    assign wr_word = cmd.alloc_wr
                   ? (word | (WORD_BITS'(1) << idx_reg[BIT_W-1:0]))
                   : (word & ~(WORD_BITS'(1) << free_bit));
    assign hint_next = (idx_reg == last_idx) ? '0 : idx_reg + IDX_W'(1);
    assign pages_next = (cfg_index == REG_REGION_PAGES) ? cfg_data[PAGE_CNT_W-1:0] : pages_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_mem[row_reg] <= wr_word;
        end
        if (rd_en)
        begin
            rdata_reg <= map_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            pages_reg     <= PAGE_CNT_W'(DEF_REGION_PAGES);
            valid_reg     <= '0;
            rvalid_reg    <= 1'b0;
            hint_reg      <= '0;
            free_reg      <= clamp_pages(PAGE_CNT_W'(DEF_REGION_PAGES));
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_BASE_PAGE)
                begin
                    base_reg <= cfg_data[FRAME_W-1:0];
                end
                pages_reg <= pages_next;
                valid_reg <= '0;
                hint_reg  <= '0;
                free_reg  <= clamp_pages(pages_next);
            end
            else
            begin
                if (wr_en)
                begin
                    valid_reg[row_reg] <= 1'b1;
                end
                if (cmd.alloc_wr)
                begin
                    hint_reg <= hint_next;
                    free_reg <= free_reg - PAGE_CNT_W'(1);
                end
                else if (cmd.free_wr)
                begin
                    free_reg <= free_reg + PAGE_CNT_W'(1);
                end
            end
            if (rd_en)
            begin
                rvalid_reg <= valid_reg[rd_addr];
            end
            if (cmd.respond)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= s_tuser;
            pn_reg    <= s_tdata[FRAME_W-1:0];
            frame_reg <= '0;
        end
        if (cmd.sub)
        begin
            diff_reg <= {1'b0, pn_reg} - {1'b0, base_reg};
        end
        if (cmd.rd_first)
        begin
            row_reg   <= start_row;
            first_reg <= 1'b1;
        end
        else if (cmd.rd_next)
        begin
            row_reg   <= next_row;
            first_reg <= 1'b0;
        end
        else if (cmd.rd_free)
        begin
            row_reg   <= free_row;
            first_reg <= 1'b0;
        end
        if (cmd.capture)
        begin
            idx_reg <= {row_reg, hit_bit};
        end
        if (cmd.alloc_wr)
        begin
            frame_reg <= base_reg + FRAME_W'(idx_reg);
        end
        if (cmd.respond)
        begin
            out_status_reg <= cmd.code;
            out_frame_reg  <= frame_reg;
            out_count_reg  <= free_reg;
        end
    end

    assign stat.mode_free = (mode_reg == MODE_FREE);
    assign stat.no_free   = (free_reg == '0);
    assign stat.hit       = hit;
    assign stat.in_range  = !diff_reg[FRAME_W]
                         && (diff_reg[FRAME_W-1:0] < FRAME_W'(eff_pages));
    assign stat.bit_set   = word[free_bit];
    assign stat.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_count_reg, out_frame_reg};
    assign m_tuser  = out_status_reg;

endmodule

@@ rtl/bitmap_page_allocator.sv @@
// bitmap page allocator, top level
// depends on bpa_pkg, bpa_ctrl and bpa_datapath
//
// usage:
// - slave stream carries requests: s_tuser is the operation (0 allocate,
//   1 free), s_tdata holds the frame number to free
// - master stream carries one response per request: m_tuser is the status,
//   m_tdata holds the allocated frame number and the free page count
// - cfg_we/cfg_index/cfg_data set the region base and page count; any write
//   clears the map, resets the hint and reloads the free count; write only
//   while no request is in flight
// - one request is handled at a time; the response register lets the next
//   request be taken while a response still waits for m_tready
// - free: S_DECODE forms the region offset, S_FREE_CHK checks the range and reads the map word,
//   S_FREE_EVAL clears the bit or reports a double free, then S_RESP; a frame outside the region
//   goes from S_FREE_CHK straight to S_RESP
// - allocate: S_DECODE reads the hint's map word, S_SCAN reads one further map word per miss
//   (64-bit words, 256-bit above 16384 pages, one read port) and wraps around the region,
//   S_ALLOC_WR sets the bit, then S_RESP; with no free page S_DECODE goes straight to S_RESP;
//   s_tready comes back together with the registered response; reset clears the map through
//   per-word valid flags, no clearing pass; s_tready is high right after reset
// - a stalled m_tready holds the response and keeps the next one back
module bitmap_page_allocator #(
    parameter int MAX_PAGES = bpa_pkg::DEF_MAX_PAGES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bpa_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bpa_pkg::S_TDATA_W-1:0]     s_tdata,   // page_number[51:0]
    input  logic                              s_tuser,   // mode
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bpa_pkg::M_TDATA_W-1:0]     m_tdata,   // page_number_res[51:0], free_count[64:52]
    output logic [1:0]                        m_tuser    // status
);
    import bpa_pkg::*;

    bpa_cmd_t  cmd;
    bpa_stat_t stat;

    bpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bpa_datapath #(
        .MAX_PAGES (MAX_PAGES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

@@ rtl/bpa_checker.sv @@
// port-level checks of the bitmap page allocator, bound to the top level
// depends on bpa_pkg and bitmap_page_allocator_assert.svh
`include "bitmap_page_allocator_assert.svh"

module bpa_checker #(
    parameter int MAX_PAGES = bpa_pkg::DEF_MAX_PAGES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [bpa_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic [1:0]                        m_tuser
);
    import bpa_pkg::*;

    `BPA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "response changed while stalled")

    `BPA_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready,
        !s_tready, "request taken while another is in flight")

    `BPA_ASSERT_IMPL(a_count_bound, m_tvalid,
        32'(m_tdata[FRAME_W +: PAGE_CNT_W]) <= MAX_PAGES, "free count above map depth")

    `BPA_ASSERT_IMPL(a_frame_zero, m_tvalid && (m_tuser != ST_OK),
        m_tdata[FRAME_W-1:0] == '0, "frame number set on a failed request")

    `BPA_ASSERT_IMPL(a_no_free_empty, m_tvalid && (m_tuser == ST_NO_FREE),
        m_tdata[FRAME_W +: PAGE_CNT_W] == '0, "no free page reported with pages left")

endmodule

bind bitmap_page_allocator bpa_checker #(
    .MAX_PAGES (MAX_PAGES)
) u_bpa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
